[rtl/ihex_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ihex_pkg
// Shared types, codes and helpers for the Intel HEX record parser.
// -----------------------------------------------------------------------------
package ihex_pkg;

  // Result kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_EOF   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_HEADER    = 3'd1;
  localparam logic [2:0] ERR_TYPE      = 3'd2;
  localparam logic [2:0] ERR_CHECKSUM  = 3'd3;
  localparam logic [2:0] ERR_DIGIT     = 3'd4;

  // Record types
  localparam logic [7:0] REC_DATA     = 8'h00;
  localparam logic [7:0] REC_EOF      = 8'h01;
  localparam logic [7:0] REC_SEGMENT  = 8'h02;
  localparam logic [7:0] REC_START_SEG = 8'h03;
  localparam logic [7:0] REC_LINEAR   = 8'h04;

  // Characters
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;

  localparam logic [15:0] LINE_MAX  = 16'hffff;
  localparam logic [31:0] LINEAR_MASK = 32'hffff0000;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [2:0]  error_code;
    logic [15:0] line_number;
  } result_t;

  // Decode one ASCII hex digit, upper or lower case
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.ok    = 1'b0;
    d.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.ok    = 1'b1;
      d.value = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      d.ok    = 1'b1;
      d.value = c[3:0] + 4'd9;
    end
    return d;
  endfunction

endpackage

[rtl/ihex_if.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ihex_if
// Valid/ready channels: one for HEX text characters, one for parser results.
// -----------------------------------------------------------------------------
interface ihex_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface ihex_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] address;
  logic [7:0]  data_byte;
  logic [2:0]  error_code;
  logic [15:0] line_number;

  modport source (output valid, output kind, output address, output data_byte,
                  output error_code, output line_number, input ready);
  modport sink   (input valid, input kind, input address, input data_byte,
                  input error_code, input line_number, output ready);
endinterface

[rtl/intel_hex_record_parser.sv]
`timescale 1ns / 1ps
// Path: input register (character transferred in), then result register.
// Throughput: one character per cycle unless the output stalls; the record
//   state advances in one pass.
// A stalled output holds one result while one more character waits in the
//   input register. Synchronous active-low reset returns to waiting for a colon.
// -----------------------------------------------------------------------------
// intel_hex_record_parser
// Parses Intel HEX text one character at a time and emits memory writes,
// end of file and error events.
// -----------------------------------------------------------------------------
module intel_hex_record_parser
  import ihex_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  ihex_char_if.sink     in_chan,
  ihex_result_if.source out_chan
);

  localparam logic [3:0] PH_WAIT   = 4'd0;
  localparam logic [3:0] PH_COUNT  = 4'd1;
  localparam logic [3:0] PH_OFFSET = 4'd2;
  localparam logic [3:0] PH_TYPE   = 4'd3;
  localparam logic [3:0] PH_DATA   = 4'd4;
  localparam logic [3:0] PH_EXT    = 4'd5;
  localparam logic [3:0] PH_SKIP   = 4'd6;
  localparam logic [3:0] PH_CHECK  = 4'd7;
  localparam logic [3:0] PH_EOL    = 4'd8;

  // Input register
  logic       in_valid_r;
  logic [7:0] in_ch_r;

  // Record state
  logic [3:0]  phase_r, phase_nxt;
  logic [2:0]  nib_r, nib_nxt;
  logic [15:0] accum_r, accum_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  rec_type_r, rec_type_nxt;
  logic [31:0] base_r, base_nxt;
  logic [31:0] waddr_r, waddr_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [15:0] line_r, line_nxt;
  logic        finished_r, finished_nxt;

  // Result register
  logic    out_valid_r;
  result_t out_r;

  logic       fire;
  logic       res_valid;
  result_t    res;
  hex_digit_t dig;
  logic [15:0] acc_new;
  logic [2:0]  nib_new;
  logic [7:0]  left_dec;
  logic        is_eol;

  // Process the held character when the result register is free or draining
  assign fire         = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || fire;

  assign dig      = hex_decode(in_ch_r);
  assign acc_new  = {accum_r[11:0], dig.value};
  assign nib_new  = nib_r + 3'd1;
  assign left_dec = left_r - 8'd1;
  assign is_eol   = (in_ch_r == CHAR_CR) || (in_ch_r == CHAR_LF);

  // Parse one character
  always_comb begin
    phase_nxt      = phase_r;
    nib_nxt        = nib_r;
    accum_nxt      = accum_r;
    byte_count_nxt = byte_count_r;
    rec_type_nxt   = rec_type_r;
    base_nxt       = base_r;
    waddr_nxt      = waddr_r;
    sum_nxt        = sum_r;
    left_nxt       = left_r;
    line_nxt       = line_r;
    finished_nxt   = finished_r;
    res_valid      = 1'b0;
    res            = '0;
    res.line_number = line_r;

    if (fire && !finished_r) begin
      if (phase_r == PH_WAIT) begin
        if (in_ch_r == CHAR_COLON) begin
          sum_nxt   = 8'd0;
          phase_nxt = PH_COUNT;
          nib_nxt   = 3'd0;
          accum_nxt = 16'd0;
        end else if (!is_eol) begin
          finished_nxt   = 1'b1;
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_HEADER;
        end
      end else if (phase_r == PH_EOL) begin
        if (is_eol) phase_nxt = PH_WAIT;
      end else if (!dig.ok) begin
        finished_nxt   = 1'b1;
        res_valid      = 1'b1;
        res.kind       = KIND_ERROR;
        res.error_code = (phase_r <= PH_TYPE) ? ERR_HEADER : ERR_DIGIT;
      end else begin
        accum_nxt = acc_new;
        nib_nxt   = nib_new;
        unique case (phase_r)
          PH_COUNT: begin
            if (nib_new == 3'd2) begin
              byte_count_nxt = acc_new[7:0];
              sum_nxt        = sum_r + acc_new[7:0];
              phase_nxt      = PH_OFFSET;
              nib_nxt        = 3'd0;
              accum_nxt      = 16'd0;
            end
          end
          PH_OFFSET: begin
            if (nib_new == 3'd4) begin
              sum_nxt   = sum_r + acc_new[15:8] + acc_new[7:0];
              waddr_nxt = base_r + {16'd0, acc_new};
              phase_nxt = PH_TYPE;
              nib_nxt   = 3'd0;
              accum_nxt = 16'd0;
            end
          end
          PH_TYPE: begin
            if (nib_new == 3'd2) begin
              rec_type_nxt = acc_new[7:0];
              sum_nxt      = sum_r + acc_new[7:0];
              left_nxt     = byte_count_r;
              nib_nxt      = 3'd0;
              accum_nxt    = 16'd0;
              case (acc_new[7:0])
                REC_DATA:      phase_nxt = (byte_count_r != 8'd0) ? PH_DATA : PH_CHECK;
                REC_START_SEG: phase_nxt = (byte_count_r != 8'd0) ? PH_SKIP : PH_CHECK;
                REC_SEGMENT, REC_LINEAR: phase_nxt = PH_EXT;
                REC_EOF: begin
                  finished_nxt = 1'b1;
                  res_valid    = 1'b1;
                  res.kind     = KIND_EOF;
                end
                default: begin
                  finished_nxt   = 1'b1;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_TYPE;
                end
              endcase
            end
          end
          PH_DATA: begin
            if (nib_new == 3'd2) begin
              sum_nxt       = sum_r + acc_new[7:0];
              waddr_nxt     = waddr_r + 32'd1;
              left_nxt      = left_dec;
              phase_nxt     = (left_dec != 8'd0) ? PH_DATA : PH_CHECK;
              nib_nxt       = 3'd0;
              accum_nxt     = 16'd0;
              res_valid     = 1'b1;
              res.kind      = KIND_WRITE;
              res.address   = waddr_r;
              res.data_byte = acc_new[7:0];
            end
          end
          PH_SKIP: begin
            if (nib_new == 3'd2) begin
              sum_nxt   = sum_r + acc_new[7:0];
              left_nxt  = left_dec;
              phase_nxt = (left_dec != 8'd0) ? PH_SKIP : PH_CHECK;
              nib_nxt   = 3'd0;
              accum_nxt = 16'd0;
            end
          end
          PH_EXT: begin
            if (nib_new == 3'd4) begin
              sum_nxt = sum_r + acc_new[15:8] + acc_new[7:0];
              if (rec_type_r == REC_SEGMENT) begin
                base_nxt = {12'd0, acc_new, 4'd0};
              end else begin
                base_nxt = {acc_new, 16'd0} & LINEAR_MASK;
              end
              phase_nxt = PH_CHECK;
              nib_nxt   = 3'd0;
              accum_nxt = 16'd0;
            end
          end
          PH_CHECK: begin
            if (nib_new == 3'd2) begin
              if ((sum_r + acc_new[7:0]) != 8'd0) begin
                finished_nxt   = 1'b1;
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_CHECKSUM;
              end else begin
                if (line_r != LINE_MAX) line_nxt = line_r + 16'd1;
                phase_nxt = PH_EOL;
                nib_nxt   = 3'd0;
                accum_nxt = 16'd0;
              end
            end
          end
          default: begin
            phase_nxt = PH_WAIT;
            nib_nxt   = 3'd0;
            accum_nxt = 16'd0;
          end
        endcase
      end
    end
  end

  // Hold one character until it is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
    if (in_chan.ready && in_chan.valid) in_ch_r <= in_chan.ch;
  end

  // Advance record state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT;
      nib_r        <= 3'd0;
      accum_r      <= 16'd0;
      byte_count_r <= 8'd0;
      rec_type_r   <= 8'd0;
      base_r       <= 32'd0;
      waddr_r      <= 32'd0;
      sum_r        <= 8'd0;
      left_r       <= 8'd0;
      line_r       <= 16'd1;
      finished_r   <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      nib_r        <= nib_nxt;
      accum_r      <= accum_nxt;
      byte_count_r <= byte_count_nxt;
      rec_type_r   <= rec_type_nxt;
      base_r       <= base_nxt;
      waddr_r      <= waddr_nxt;
      sum_r        <= sum_nxt;
      left_r       <= left_nxt;
      line_r       <= line_nxt;
      finished_r   <= finished_nxt;
    end
  end

  // Load the result register, drop it once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= res_valid;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (fire && res_valid) out_r <= res;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.kind        = out_r.kind;
  assign out_chan.address     = out_r.address;
  assign out_chan.data_byte   = out_r.data_byte;
  assign out_chan.error_code  = out_r.error_code;
  assign out_chan.line_number = out_r.line_number;

  // End of file and errors are sticky
  a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |=> finished_r)
    else $error("finished flag cleared without reset");

  // An end or error event stops the parser
  a_event_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_valid && res.kind != KIND_WRITE) |=> finished_r)
    else $error("end or error event did not stop the parser");

  // Nothing is produced after the parser has stopped
  a_quiet_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> !res_valid)
    else $error("result produced after end of file or error");

  // Line counter starts at one and saturates, so it never reads zero
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != 16'd0)
    else $error("line counter wrapped to zero");

endmodule
